FILE: sv/mrrts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mrrts_pkg;

    localparam int TASK_W = 22;

    localparam logic [2:0] ACT_ARRIVE   = 3'd0;
    localparam logic [2:0] ACT_FINISH   = 3'd1;
    localparam logic [2:0] ACT_REPORT   = 3'd2;
    localparam logic [2:0] ACT_DECIDE   = 3'd3;
    localparam logic [2:0] ACT_FINALIZE = 3'd4;

    localparam logic [3:0] RK_ACCEPTED     = 4'd0;
    localparam logic [3:0] RK_QUEUE_FULL   = 4'd1;
    localparam logic [3:0] RK_FINISHED     = 4'd2;
    localparam logic [3:0] RK_NOT_FOUND    = 4'd3;
    localparam logic [3:0] RK_REPORT       = 4'd4;
    localparam logic [3:0] RK_EXECUTE      = 4'd5;
    localparam logic [3:0] RK_PARK         = 4'd6;
    localparam logic [3:0] RK_STOPPED      = 4'd7;
    localparam logic [3:0] RK_CONFIRMED    = 4'd8;
    localparam logic [3:0] RK_DISCARDED    = 4'd9;
    localparam logic [3:0] RK_REQUEUED     = 4'd10;
    localparam logic [3:0] RK_REQUEUED_BAD = 4'd11;
    localparam logic [3:0] RK_PARK_RETURN  = 4'd12;
    localparam logic [3:0] RK_PARK_UNKNOWN = 4'd13;
    localparam logic [3:0] RK_PARK_FULL    = 4'd14;
    localparam logic [3:0] RK_PASS_DONE    = 4'd15;

    localparam logic [1:0] REG_CYCLES_PER_US = 2'd0;
    localparam logic [1:0] REG_QUANTUM_US    = 2'd1;
    localparam logic [1:0] REG_CORE_MASK     = 2'd2;

    typedef struct packed {
        logic [15:0] cycles_per_microsecond;
        logic [15:0] quantum_microseconds;
        logic [7:0]  active_core_mask;
    } cfg_t;

    typedef struct packed {
        logic full;
        logic nonempty;
    } qstat_t;

    typedef struct packed {
        logic [3:0]        kind;
        logic [2:0]        core;
        logic [TASK_W-1:0] task_id;
        logic              last;
    } res_t;

    function automatic res_t mk_res(logic [3:0] kind, logic [2:0] core,
                                    logic [TASK_W-1:0] task_id, logic last);
        res_t r;
        r.kind    = kind;
        r.core    = core;
        r.task_id = task_id;
        r.last    = last;
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: sv/mrrts_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface mrrts_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [21:0] task_number;
    logic [2:0]  core_index;
    logic [63:0] now_cycles;
    logic [63:0] reported_started_at;
    logic [21:0] reported_running_id;
    logic [21:0] reported_next_id;
    logic [21:0] reported_parked_id;
    logic        reported_park_request;

    modport source (output valid, action, task_number, core_index, now_cycles,
                    reported_started_at, reported_running_id, reported_next_id,
                    reported_parked_id, reported_park_request, input ready);
    modport sink (input valid, action, task_number, core_index, now_cycles,
                  reported_started_at, reported_running_id, reported_next_id,
                  reported_parked_id, reported_park_request, output ready);
endinterface

interface mrrts_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  result_kind;
    logic [2:0]  result_core;
    logic [21:0] result_task;
    logic        last_result;

    modport source (output valid, result_kind, result_core, result_task, last_result,
                    input ready);
    modport sink (input valid, result_kind, result_core, result_task, last_result,
                  output ready);
endinterface
`default_nettype wire

FILE: sv/mrrts_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module mrrts_queue #(
    parameter int QUEUE_DEPTH = 64
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    input  wire logic [mrrts_pkg::TASK_W-1:0] push_data,
    input  wire logic                       pop,
    output logic [mrrts_pkg::TASK_W-1:0]    rdata,
    output mrrts_pkg::qstat_t               stat
);
    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    logic [mrrts_pkg::TASK_W-1:0] mem [QUEUE_DEPTH];
    logic [QW-1:0] head_reg;
    logic [QW-1:0] tail_reg;
    logic [NW-1:0] count_reg;
    logic [mrrts_pkg::TASK_W-1:0] rdata_reg;

    assign stat.full     = (count_reg == NW'(QUEUE_DEPTH));
    assign stat.nonempty = (count_reg != '0);
    assign rdata         = rdata_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[tail_reg] <= push_data;
        end
        if (pop)
        begin
            rdata_reg <= mem[head_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                tail_reg <= (tail_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
            end
            if (pop)
            begin
                head_reg <= (head_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

FILE: sv/mrrts_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
module mrrts_cfg (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output mrrts_pkg::cfg_t  cfg
);
    mrrts_pkg::cfg_t cfg_reg;
    logic            wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_comb
    begin
        case (paddr[3:2])
            mrrts_pkg::REG_CYCLES_PER_US: prdata = {16'd0, cfg_reg.cycles_per_microsecond};
            mrrts_pkg::REG_QUANTUM_US:    prdata = {16'd0, cfg_reg.quantum_microseconds};
            mrrts_pkg::REG_CORE_MASK:     prdata = {24'd0, cfg_reg.active_core_mask};
            default:                      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cycles_per_microsecond <= 16'd1000;
            cfg_reg.quantum_microseconds   <= 16'd10;
            cfg_reg.active_core_mask       <= 8'hFF;
        end
        else if (wr)
        begin
            case (paddr[3:2])
                mrrts_pkg::REG_CYCLES_PER_US: cfg_reg.cycles_per_microsecond <= pwdata[15:0];
                mrrts_pkg::REG_QUANTUM_US:    cfg_reg.quantum_microseconds   <= pwdata[15:0];
                mrrts_pkg::REG_CORE_MASK:     cfg_reg.active_core_mask       <= pwdata[7:0];
                default:                      cfg_reg <= cfg_reg;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: sv/multicore_round_robin_task_scheduler.sv
`timescale 1ns / 1ps
`default_nettype none
// Round-robin time-slice scheduler for up to eight cores with one FIFO run queue.
// in_req carries one event request (arrive, finish, core report, decide pass,
// finalize pass); out_res returns its results one at a time, last_result set on
// the final one. Both use valid/ready; a request is taken only when the block is
// idle, and one request is worked on at a time.
// Arrive and report give one result; finish walks the core slots until it finds
// the task; a decide pass walks them up to the first park request, with an
// extra state per queue pop; a finalize pass walks them twice, requests then
// parked tasks, or only gives pass done right after a stopped decide pass. The
// walk takes one core per cycle; the next request is taken the cycle after the
// final result is loaded. A finished result sits in an output register; the
// walk holds whenever a result is due and that register is full, so a stalled
// receiver stalls the pass. Reset empties the queue, clears all per-core words
// and the park table and loads the default configuration; the queue memory is
// not cleared. Configuration goes over the APB port; the user must write it
// only while the block is idle, as the block does not enforce it.
module multicore_round_robin_task_scheduler #(
    parameter int CORES       = 8,
    parameter int QUEUE_DEPTH = 64,
    parameter int PARK_DEPTH  = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    mrrts_in_if.sink         in_req,
    mrrts_out_if.source      out_res,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    localparam int TW = mrrts_pkg::TASK_W;
    localparam int NC = (CORES < 8) ? CORES : 8;
    localparam int CW = $clog2(NC + 1);
    localparam int IW = (NC > 1) ? $clog2(NC) : 1;
    localparam int PW = (PARK_DEPTH > 1) ? $clog2(PARK_DEPTH) : 1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_ARRIVE, ST_FINISH, ST_REPORT, ST_DEC_INIT, ST_DEC_CORE,
        ST_DEC_POP, ST_FIN_STOP, ST_FIN_REQ, ST_FIN_PARK
    } state_t;

    mrrts_pkg::cfg_t   cfg;
    mrrts_pkg::qstat_t q_stat;
    mrrts_pkg::res_t   res_reg;

    state_t         state_reg;
    logic [CW-1:0]  cnt_reg;
    logic           out_valid_reg;
    logic           stop_reg;
    logic [31:0]    slice_reg;
    logic [TW-1:0]  task_reg;
    logic [2:0]     core_reg;
    logic [63:0]    now_reg;
    logic [63:0]    rep_started_reg;
    logic [TW-1:0]  rep_running_reg;
    logic [TW-1:0]  rep_next_reg;
    logic [TW-1:0]  rep_parked_reg;
    logic           rep_flag_reg;

    logic           run_valid_reg  [NC];
    logic [TW-1:0]  run_task_reg   [NC];
    logic           req_valid_reg  [NC];
    logic [TW-1:0]  req_task_reg   [NC];
    logic [TW-1:0]  running_reg    [NC];
    logic [63:0]    started_reg    [NC];
    logic [TW-1:0]  next_reg       [NC];
    logic [TW-1:0]  parked_reg     [NC];
    logic           park_flag_reg  [NC];
    logic           pk_valid_reg   [PARK_DEPTH];
    logic [TW-1:0]  pk_id_reg      [PARK_DEPTH];

    logic [IW-1:0]  ci;
    logic           walk_end;
    logic           act;
    logic           ok;
    logic [TW-1:0]  lookup_id;
    logic           pk_hit;
    logic [PW-1:0]  pk_hit_idx;
    logic           pk_free;
    logic [PW-1:0]  pk_free_idx;
    logic           over_slice;
    logic           park_cond;
    logic           q_push;
    logic [TW-1:0]  q_push_data;
    logic           q_pop;
    logic [TW-1:0]  q_rdata;
    logic           core_ok;

    mrrts_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mrrts_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .rdata     (q_rdata),
        .stat      (q_stat)
    );

    assign ci         = cnt_reg[IW-1:0];
    assign walk_end   = (cnt_reg == CW'(NC));
    assign act        = cfg.active_core_mask[ci];
    assign ok         = !out_valid_reg || out_res.ready;
    assign lookup_id  = (state_reg == ST_DEC_CORE) ? run_task_reg[ci] : parked_reg[ci];
    assign over_slice = (now_reg - started_reg[ci]) > {32'd0, slice_reg};
    assign park_cond  = q_stat.nonempty && over_slice && run_valid_reg[ci];
    assign core_ok    = (4'(core_reg) < 4'(NC));

    assign in_req.ready        = (state_reg == ST_IDLE);
    assign out_res.valid       = out_valid_reg;
    assign out_res.result_kind = res_reg.kind;
    assign out_res.result_core = res_reg.core;
    assign out_res.result_task = res_reg.task_id;
    assign out_res.last_result = res_reg.last;

    // lowest matching slot and lowest free slot of the park table
    always_comb
    begin
        pk_hit      = 1'b0;
        pk_hit_idx  = '0;
        pk_free     = 1'b0;
        pk_free_idx = '0;
        for (int k = PARK_DEPTH - 1; k >= 0; k--)
        begin
            if (pk_valid_reg[k] && pk_id_reg[k] == lookup_id)
            begin
                pk_hit     = 1'b1;
                pk_hit_idx = PW'(k);
            end
            if (!pk_valid_reg[k])
            begin
                pk_free     = 1'b1;
                pk_free_idx = PW'(k);
            end
        end
    end

    always_comb
    begin
        q_push      = 1'b0;
        q_push_data = task_reg;
        q_pop       = 1'b0;
        case (state_reg)
            ST_ARRIVE:
            begin
                q_push = ok && !q_stat.full;
            end
            ST_FIN_REQ:
            begin
                q_push_data = req_task_reg[ci];
                q_push = ok && !walk_end && act && req_valid_reg[ci]
                         && next_reg[ci] != '0 && !q_stat.full;
            end
            ST_FIN_PARK:
            begin
                q_push_data = parked_reg[ci];
                q_push = ok && !walk_end && act && parked_reg[ci] != '0
                         && pk_hit && !q_stat.full;
            end
            ST_DEC_CORE:
            begin
                q_pop = !walk_end && act && !park_flag_reg[ci]
                        && running_reg[ci] == '0 && q_stat.nonempty;
            end
            default:
            begin
                q_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cnt_reg         <= '0;
            out_valid_reg   <= 1'b0;
            res_reg         <= '0;
            stop_reg        <= 1'b0;
            slice_reg       <= '0;
            task_reg        <= '0;
            core_reg        <= '0;
            now_reg         <= '0;
            rep_started_reg <= '0;
            rep_running_reg <= '0;
            rep_next_reg    <= '0;
            rep_parked_reg  <= '0;
            rep_flag_reg    <= 1'b0;
            for (int i = 0; i < NC; i++)
            begin
                run_valid_reg[i] <= 1'b0;
                run_task_reg[i]  <= '0;
                req_valid_reg[i] <= 1'b0;
                req_task_reg[i]  <= '0;
                running_reg[i]   <= '0;
                started_reg[i]   <= '0;
                next_reg[i]      <= '0;
                parked_reg[i]    <= '0;
                park_flag_reg[i] <= 1'b0;
            end
            for (int k = 0; k < PARK_DEPTH; k++)
            begin
                pk_valid_reg[k] <= 1'b0;
                pk_id_reg[k]    <= '0;
            end
        end
        else
        begin
            logic res_load;
            res_load = 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_req.valid)
                    begin
                        task_reg        <= in_req.task_number;
                        core_reg        <= in_req.core_index;
                        now_reg         <= in_req.now_cycles;
                        rep_started_reg <= in_req.reported_started_at;
                        rep_running_reg <= in_req.reported_running_id;
                        rep_next_reg    <= in_req.reported_next_id;
                        rep_parked_reg  <= in_req.reported_parked_id;
                        rep_flag_reg    <= in_req.reported_park_request;
                        cnt_reg         <= '0;
                        case (in_req.action)
                            mrrts_pkg::ACT_ARRIVE:   state_reg <= ST_ARRIVE;
                            mrrts_pkg::ACT_FINISH:   state_reg <= ST_FINISH;
                            mrrts_pkg::ACT_REPORT:   state_reg <= ST_REPORT;
                            mrrts_pkg::ACT_DECIDE:   state_reg <= ST_DEC_INIT;
                            mrrts_pkg::ACT_FINALIZE:
                                state_reg <= stop_reg ? ST_FIN_STOP : ST_FIN_REQ;
                            default:                 state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_ARRIVE:
                begin
                    if (ok)
                    begin
                        res_reg <= mrrts_pkg::mk_res(q_stat.full ? mrrts_pkg::RK_QUEUE_FULL
                                   : mrrts_pkg::RK_ACCEPTED, 3'd0, task_reg, 1'b1);
                        res_load  = 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                ST_FINISH:
                begin
                    if (walk_end)
                    begin
                        if (ok)
                        begin
                            res_reg <= mrrts_pkg::mk_res(mrrts_pkg::RK_NOT_FOUND, 3'd0,
                                                         task_reg, 1'b1);
                            res_load  = 1'b1;
                            state_reg <= ST_IDLE;
                        end
                    end
                    else if (run_valid_reg[ci] && run_task_reg[ci] == task_reg)
                    begin
                        if (ok)
                        begin
                            run_valid_reg[ci] <= 1'b0;
                            run_task_reg[ci]  <= '0;
                            res_reg <= mrrts_pkg::mk_res(mrrts_pkg::RK_FINISHED, 3'(cnt_reg),
                                                         task_reg, 1'b1);
                            res_load  = 1'b1;
                            state_reg <= ST_IDLE;
                        end
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_REPORT:
                begin
                    if (ok)
                    begin
                        if (core_ok)
                        begin
                            started_reg[core_reg[IW-1:0]]   <= rep_started_reg;
                            running_reg[core_reg[IW-1:0]]   <= rep_running_reg;
                            next_reg[core_reg[IW-1:0]]      <= rep_next_reg;
                            parked_reg[core_reg[IW-1:0]]    <= rep_parked_reg;
                            park_flag_reg[core_reg[IW-1:0]] <= rep_flag_reg;
                        end
                        res_reg <= mrrts_pkg::mk_res(mrrts_pkg::RK_REPORT, core_reg,
                                                     '0, 1'b1);
                        res_load  = 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                ST_DEC_INIT:
                begin
                    slice_reg <= 32'(cfg.cycles_per_microsecond)
                                 * 32'(cfg.quantum_microseconds);
                    stop_reg  <= 1'b0;
                    state_reg <= ST_DEC_CORE;
                end
                ST_DEC_CORE:
                begin
                    if (walk_end)
                    begin
                        if (ok)
                        begin
                            res_reg <= mrrts_pkg::mk_res(mrrts_pkg::RK_PASS_DONE, 3'd0,
                                                         '0, 1'b1);
                            res_load  = 1'b1;
                            state_reg <= ST_IDLE;
                        end
                    end
                    else if (!act)
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    else if (park_flag_reg[ci])
                    begin
                        if (ok)
                        begin
                            stop_reg <= 1'b1;
                            res_reg <= mrrts_pkg::mk_res(mrrts_pkg::RK_STOPPED, 3'(cnt_reg),
                                                         '0, 1'b1);
                            res_load  = 1'b1;
                            state_reg <= ST_IDLE;
                        end
                    end
                    else if (running_reg[ci] != '0)
                    begin
                        if (!park_cond)
                        begin
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                        else if (ok)
                        begin
                            if (pk_hit || pk_free)
                            begin
                                pk_valid_reg[pk_hit ? pk_hit_idx : pk_free_idx] <= 1'b1;
                                pk_id_reg[pk_hit ? pk_hit_idx : pk_free_idx] <= lookup_id;
                                park_flag_reg[ci] <= 1'b1;
                                run_valid_reg[ci] <= 1'b0;
                                run_task_reg[ci]  <= '0;
                                res_reg <= mrrts_pkg::mk_res(mrrts_pkg::RK_PARK,
                                                             3'(cnt_reg), lookup_id, 1'b0);
                            end
                            else
                            begin
                                res_reg <= mrrts_pkg::mk_res(mrrts_pkg::RK_PARK_FULL,
                                                             3'(cnt_reg), lookup_id, 1'b0);
                            end
                            res_load = 1'b1;
                            cnt_reg  <= cnt_reg + 1'b1;
                        end
                    end
                    else if (q_stat.nonempty)
                    begin
                        state_reg <= ST_DEC_POP;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_DEC_POP:
                begin
                    // queue head arrives from memory this cycle
                    if (ok)
                    begin
                        next_reg[ci]      <= q_rdata;
                        req_valid_reg[ci] <= 1'b1;
                        req_task_reg[ci]  <= q_rdata;
                        res_reg <= mrrts_pkg::mk_res(mrrts_pkg::RK_EXECUTE, 3'(cnt_reg),
                                                     q_rdata, 1'b0);
                        res_load  = 1'b1;
                        cnt_reg   <= cnt_reg + 1'b1;
                        state_reg <= ST_DEC_CORE;
                    end
                end
                ST_FIN_STOP:
                begin
                    if (ok)
                    begin
                        stop_reg <= 1'b0;
                        res_reg <= mrrts_pkg::mk_res(mrrts_pkg::RK_PASS_DONE, 3'd0,
                                                     '0, 1'b1);
                        res_load  = 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                ST_FIN_REQ:
                begin
                    if (walk_end)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_FIN_PARK;
                    end
                    else if (!act || !req_valid_reg[ci])
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    else if (ok)
                    begin
                        req_valid_reg[ci] <= 1'b0;
                        req_task_reg[ci]  <= '0;
                        if (next_reg[ci] == '0)
                        begin
                            if (running_reg[ci] == req_task_reg[ci])
                            begin
                                run_valid_reg[ci] <= 1'b1;
                                run_task_reg[ci]  <= req_task_reg[ci];
                                res_reg <= mrrts_pkg::mk_res(mrrts_pkg::RK_CONFIRMED,
                                           3'(cnt_reg), req_task_reg[ci], 1'b0);
                            end
                            else
                            begin
                                res_reg <= mrrts_pkg::mk_res(mrrts_pkg::RK_DISCARDED,
                                           3'(cnt_reg), req_task_reg[ci], 1'b0);
                            end
                        end
                        else
                        begin
                            if (next_reg[ci] == req_task_reg[ci])
                            begin
                                next_reg[ci] <= '0;
                            end
                            res_reg <= mrrts_pkg::mk_res(
                                q_stat.full ? mrrts_pkg::RK_QUEUE_FULL
                                : (next_reg[ci] == req_task_reg[ci])
                                  ? mrrts_pkg::RK_REQUEUED : mrrts_pkg::RK_REQUEUED_BAD,
                                3'(cnt_reg), req_task_reg[ci], 1'b0);
                        end
                        res_load = 1'b1;
                        cnt_reg  <= cnt_reg + 1'b1;
                    end
                end
                ST_FIN_PARK:
                begin
                    if (walk_end)
                    begin
                        if (ok)
                        begin
                            res_reg <= mrrts_pkg::mk_res(mrrts_pkg::RK_PASS_DONE, 3'd0,
                                                         '0, 1'b1);
                            res_load  = 1'b1;
                            state_reg <= ST_IDLE;
                        end
                    end
                    else if (!act || parked_reg[ci] == '0)
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    else if (ok)
                    begin
                        if (pk_hit)
                        begin
                            pk_valid_reg[pk_hit_idx] <= 1'b0;
                            pk_id_reg[pk_hit_idx]    <= '0;
                            res_reg <= mrrts_pkg::mk_res(q_stat.full
                                       ? mrrts_pkg::RK_QUEUE_FULL : mrrts_pkg::RK_PARK_RETURN,
                                       3'(cnt_reg), parked_reg[ci], 1'b0);
                        end
                        else
                        begin
                            res_reg <= mrrts_pkg::mk_res(mrrts_pkg::RK_PARK_UNKNOWN,
                                       3'(cnt_reg), parked_reg[ci], 1'b0);
                        end
                        parked_reg[ci] <= '0;
                        res_load       = 1'b1;
                        cnt_reg        <= cnt_reg + 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
            // load a new result, else drop the one the receiver took
            if (res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("push into full run queue");

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_stat.nonempty)
        else $error("pop from empty run queue");

    a_pop_then_take: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> state_reg == ST_DEC_POP)
        else $error("queue read not followed by its take cycle");

    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        in_req.valid && in_req.ready && in_req.action <= mrrts_pkg::ACT_FINALIZE
        |=> !in_req.ready)
        else $error("new request taken while one is in work");

endmodule
`default_nettype wire

FILE: sim/mrrts_checker.sv
`timescale 1ns / 1ps
module mrrts_checker (
    input  logic        clk,
    input  logic        rst_n,
    mrrts_in_if         in_req,
    mrrts_out_if        out_res,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_idx,
    input  logic [31:0] cfg_val,
    output int          fail_count,
    output int          pending,
    output int          results_seen,
    output int          passes_seen
);
    import mrrts_pkg::*;

    localparam int NCORE = 8;
    localparam int QDEPTH = 64;
    localparam int PDEPTH = 8;

    logic [21:0] run_queue [QDEPTH];
    int          q_head, q_tail, q_count;
    logic        run_ok [NCORE];
    logic [21:0] run_task [NCORE];
    logic        req_ok [NCORE];
    logic [21:0] req_task [NCORE];
    logic [21:0] sh_running [NCORE];
    logic [63:0] sh_started [NCORE];
    logic [21:0] sh_next [NCORE];
    logic [21:0] sh_parked [NCORE];
    logic        sh_park [NCORE];
    logic        park_ok [PDEPTH];
    logic [21:0] park_task [PDEPTH];
    logic        stopped;
    logic [15:0] cpu_ticks, quantum;
    logic [7:0]  core_mask;

    res_t expected_results [$];

    function automatic void post(logic [3:0] k, int c, logic [21:0] t);
        expected_results.push_back(mk_res(k, c[2:0], t, 1'b0));
    endfunction

    function automatic bit enqueue(logic [21:0] id);
        if (q_count >= QDEPTH) return 0;
        run_queue[q_tail] = id;
        q_tail = (q_tail + 1) % QDEPTH;
        q_count++;
        return 1;
    endfunction

    function automatic int find_park(logic [21:0] id);
        for (int k = 0; k < PDEPTH; k++)
            if (park_ok[k] && park_task[k] == id) return k;
        return -1;
    endfunction

    function automatic void run_decide(logic [63:0] now);
        logic [63:0] slice;
        logic [21:0] id;
        int slot;
        slice = 64'(cpu_ticks) * 64'(quantum);
        stopped = 0;
        for (int c = 0; c < NCORE; c++)
        begin
            if (!core_mask[c]) continue;
            if (sh_park[c])
            begin
                stopped = 1;
                post(RK_STOPPED, c, 0);
                return;
            end
            if (sh_running[c] != 0)
            begin
                if (q_count > 0 && (now - sh_started[c]) > slice && run_ok[c])
                begin
                    id = run_task[c];
                    slot = find_park(id);
                    if (slot < 0)
                        for (int k = 0; k < PDEPTH; k++)
                            if (!park_ok[k]) begin slot = k; break; end
                    if (slot < 0) post(RK_PARK_FULL, c, id);
                    else
                    begin
                        park_ok[slot] = 1;
                        park_task[slot] = id;
                        sh_park[c] = 1;
                        run_ok[c] = 0;
                        run_task[c] = 0;
                        post(RK_PARK, c, id);
                    end
                end
            end
            else if (q_count > 0)
            begin
                id = run_queue[q_head];
                q_head = (q_head + 1) % QDEPTH;
                q_count--;
                sh_next[c] = id;
                req_ok[c] = 1;
                req_task[c] = id;
                post(RK_EXECUTE, c, id);
            end
        end
        post(RK_PASS_DONE, 0, 0);
    endfunction

    function automatic void run_finalize();
        logic [21:0] r;
        logic [3:0] k;
        int slot;
        if (stopped)
        begin
            stopped = 0;
            post(RK_PASS_DONE, 0, 0);
            return;
        end
        for (int c = 0; c < NCORE; c++)
        begin
            if (!core_mask[c] || !req_ok[c]) continue;
            r = req_task[c];
            req_ok[c] = 0;
            req_task[c] = 0;
            if (sh_next[c] == 0)
            begin
                if (sh_running[c] == r)
                begin
                    run_ok[c] = 1;
                    run_task[c] = r;
                    post(RK_CONFIRMED, c, r);
                end
                else post(RK_DISCARDED, c, r);
            end
            else
            begin
                k = RK_REQUEUED_BAD;
                if (sh_next[c] == r)
                begin
                    sh_next[c] = 0;
                    k = RK_REQUEUED;
                end
                post(enqueue(r) ? k : RK_QUEUE_FULL, c, r);
            end
        end
        for (int c = 0; c < NCORE; c++)
        begin
            if (!core_mask[c] || sh_parked[c] == 0) continue;
            r = sh_parked[c];
            slot = find_park(r);
            if (slot >= 0)
            begin
                park_ok[slot] = 0;
                park_task[slot] = 0;
                post(enqueue(r) ? RK_PARK_RETURN : RK_QUEUE_FULL, c, r);
            end
            else post(RK_PARK_UNKNOWN, c, r);
            sh_parked[c] = 0;
        end
        post(RK_PASS_DONE, 0, 0);
    endfunction

    function automatic void predict_request();
        int prior_size, c;
        logic [21:0] t;
        prior_size = expected_results.size();
        t = in_req.task_number;
        case (in_req.action)
            ACT_ARRIVE: post(enqueue(t) ? RK_ACCEPTED : RK_QUEUE_FULL, 0, t);
            ACT_FINISH:
            begin
                for (c = 0; c < NCORE; c++)
                    if (run_ok[c] && run_task[c] == t) break;
                if (c < NCORE)
                begin
                    run_ok[c] = 0;
                    run_task[c] = 0;
                    post(RK_FINISHED, c, t);
                end
                else post(RK_NOT_FOUND, 0, t);
            end
            ACT_REPORT:
            begin
                c = in_req.core_index;
                sh_started[c] = in_req.reported_started_at;
                sh_running[c] = in_req.reported_running_id;
                sh_next[c] = in_req.reported_next_id;
                sh_parked[c] = in_req.reported_parked_id;
                sh_park[c] = in_req.reported_park_request;
                post(RK_REPORT, c, 0);
            end
            ACT_DECIDE: begin run_decide(in_req.now_cycles); passes_seen++; end
            ACT_FINALIZE: begin run_finalize(); passes_seen++; end
            default: ;
        endcase
        if (expected_results.size() > prior_size)
            expected_results[expected_results.size() - 1].last = 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        res_t got, want;
        if (!rst_n)
        begin
            expected_results.delete();
            q_head = 0; q_tail = 0; q_count = 0;
            for (int c = 0; c < NCORE; c++)
            begin
                run_ok[c] = 0; run_task[c] = 0; req_ok[c] = 0; req_task[c] = 0;
                sh_running[c] = 0; sh_started[c] = 0; sh_next[c] = 0;
                sh_parked[c] = 0; sh_park[c] = 0;
            end
            for (int k = 0; k < PDEPTH; k++) begin park_ok[k] = 0; park_task[k] = 0; end
            stopped = 0;
            cpu_ticks = 1000; quantum = 10; core_mask = 8'hFF;
            fail_count = 0; pending = 0; results_seen = 0; passes_seen = 0;
        end
        else
        begin
            if (cfg_we)
                case (cfg_idx)
                    REG_CYCLES_PER_US: cpu_ticks = cfg_val[15:0];
                    REG_QUANTUM_US:    quantum = cfg_val[15:0];
                    REG_CORE_MASK:     core_mask = cfg_val[7:0];
                    default: ;
                endcase
            if (out_res.valid && out_res.ready)
            begin
                got = mk_res(out_res.result_kind, out_res.result_core,
                             out_res.result_task, out_res.last_result);
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result kind=%0d core=%0d task=%0d last=%0b",
                                 got.kind, got.core, got.task_id, got.last);
                end
                else
                begin
                    want = expected_results[0];
                    expected_results.delete(0);
                    if (got != want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                                     want.kind, want.core, want.task_id, want.last,
                                     got.kind, got.core, got.task_id, got.last);
                    end
                end
            end
            if (in_req.valid && in_req.ready)
                predict_request();
            pending = expected_results.size();
        end
    end
endmodule

FILE: sim/multicore_round_robin_task_scheduler_tb.sv
`timescale 1ns / 1ps
module multicore_round_robin_task_scheduler_tb;
    import mrrts_pkg::*;

    // action codes with no meaning, answered by nothing
    localparam logic [2:0] ACT_UNUSED_LO = 3'd5;
    localparam logic [2:0] ACT_UNUSED_HI = 3'd7;

    logic        clk;
    logic        rst_n;
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count, pending, results_seen, passes_seen;
    int          cycle_count;
    int          sent;
    bit          calm;
    logic [21:0] task_pool [16];

    mrrts_in_if  in_req ();
    mrrts_out_if out_res ();

    multicore_round_robin_task_scheduler dut (
        .clk(clk), .rst_n(rst_n), .in_req(in_req), .out_res(out_res),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    mrrts_checker u_checker (
        .clk(clk), .rst_n(rst_n), .in_req(in_req), .out_res(out_res),
        .cfg_we(psel && penable && pwrite && pready), .cfg_idx(paddr[3:2]),
        .cfg_val(pwdata), .fail_count(fail_count), .pending(pending),
        .results_seen(results_seen), .passes_seen(passes_seen)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > 400000)
        begin
            $display("multicore_round_robin_task_scheduler regression: fail");
            $finish;
        end
    end

    // receiver: random stall bursts until the calm tail
    initial
    begin
        int n;
        out_res.ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 9);
                out_res.ready <= 0;
                repeat (n) @(negedge clk);
            end
            out_res.ready <= 1;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] v);
        @(negedge clk);
        psel <= 1; pwrite <= 1; penable <= 0; paddr <= {idx, 2'b00}; pwdata <= v;
        @(negedge clk);
        penable <= 1;
        @(negedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task automatic drain();
        while (pending != 0) @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic send(logic [2:0] act, logic [21:0] t, logic [2:0] c, logic [63:0] now,
                        logic [63:0] st, logic [21:0] run, logic [21:0] nxt,
                        logic [21:0] prk, logic pf);
        if (!calm && $urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 9)) @(negedge clk);
        // the block is busy the cycle after it takes a request with a defined action code
        @(negedge clk);
        in_req.valid <= 1; in_req.action <= act; in_req.task_number <= t;
        in_req.core_index <= c; in_req.now_cycles <= now;
        in_req.reported_started_at <= st; in_req.reported_running_id <= run;
        in_req.reported_next_id <= nxt; in_req.reported_parked_id <= prk;
        in_req.reported_park_request <= pf;
        @(posedge clk);
        while (!in_req.ready) @(posedge clk);
        @(negedge clk);
        in_req.valid <= 0;
        sent++;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [21:0] pick_task();
        return ($urandom_range(0, 3) == 0) ? 22'($urandom()) : task_pool[$urandom_range(0, 15)];
    endfunction

    // one scheduling round with partner reports that mostly follow the protocol
    task automatic sched_round(logic [63:0] now);
        logic [2:0] c;
        logic [21:0] id;
        repeat ($urandom_range(0, 3))
            send(ACT_ARRIVE, pick_task(), 0, 0, 0, 0, 0, 0, 0);
        send(ACT_DECIDE, 0, 0, now, 0, 0, 0, 0, 0);
        repeat ($urandom_range(1, 4))
        begin
            c = $urandom_range(0, 7);
            id = pick_task();
            case ($urandom_range(0, 4))
                0: send(ACT_REPORT, 0, c, 0, now - $urandom_range(0, 20000), id, 0, 0, 0);
                1: send(ACT_REPORT, 0, c, 0, now, 0, id, 0, 0);
                2: send(ACT_REPORT, 0, c, 0, now, 0, 0, id, 0);
                3: send(ACT_REPORT, 0, c, 0, rand64(), id, pick_task(), pick_task(),
                        $urandom_range(0, 3) == 0);
                default: send(ACT_FINISH, pick_task(), 0, 0, 0, 0, 0, 0, 0);
            endcase
        end
        send(ACT_FINALIZE, 0, 0, 0, 0, 0, 0, 0, 0);
    endtask

    initial
    begin
        logic [63:0] now;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        in_req.valid = 0; in_req.action = 0; in_req.task_number = 0;
        in_req.core_index = 0; in_req.now_cycles = 0; in_req.reported_started_at = 0;
        in_req.reported_running_id = 0; in_req.reported_next_id = 0;
        in_req.reported_parked_id = 0; in_req.reported_park_request = 0;
        rst_n = 0; calm = 0; sent = 0; cycle_count = 0;
        for (int i = 0; i < 16; i++) task_pool[i] = 22'($urandom_range(1, 40));
        task_pool[0] = 22'h3FFFFF;
        task_pool[1] = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: all actions, extremes, full queue, stopped pass, time slice
        write_reg(REG_CYCLES_PER_US, 1);
        write_reg(REG_QUANTUM_US, 1);
        send(ACT_ARRIVE, 22'h3FFFFF, 0, 0, 0, 0, 0, 0, 0);
        send(ACT_ARRIVE, 0, 0, 0, 0, 0, 0, 0, 0);
        send(ACT_DECIDE, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 0, 0);
        send(ACT_REPORT, 0, 0, 0, 0, 22'h3FFFFF, 0, 0, 0);
        send(ACT_REPORT, 0, 1, 0, 0, 0, 22'h3FFFFF, 0, 0);
        send(ACT_FINALIZE, 0, 0, 0, 0, 0, 0, 0, 0);
        send(ACT_ARRIVE, 5, 0, 0, 0, 0, 0, 0, 0);
        send(ACT_DECIDE, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 0, 0);
        send(ACT_REPORT, 0, 7, 0, 64'hFFFF_FFFF_FFFF_FFFF, 22'h3FFFFF, 22'h3FFFFF,
             22'h3FFFFF, 1);
        send(ACT_DECIDE, 0, 0, 0, 0, 0, 0, 0, 0);
        send(ACT_FINALIZE, 0, 0, 0, 0, 0, 0, 0, 0);
        send(ACT_REPORT, 0, 0, 0, 0, 0, 0, 22'h3FFFFF, 0);
        send(ACT_FINALIZE, 0, 0, 0, 0, 0, 0, 0, 0);
        send(ACT_FINISH, 22'h3FFFFF, 0, 0, 0, 0, 0, 0, 0);
        send(ACT_FINISH, 77, 0, 0, 0, 0, 0, 0, 0);
        send(ACT_UNUSED_LO, 1, 0, 0, 0, 0, 0, 0, 0);
        send(ACT_UNUSED_HI, 1, 0, 0, 0, 0, 0, 0, 0);
        for (int i = 0; i < 66; i++)
            send(ACT_ARRIVE, 22'(i + 100), 0, 0, 0, 0, 0, 0, 0);
        drain();

        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: begin write_reg(REG_CYCLES_PER_US, 16'hFFFF); write_reg(REG_QUANTUM_US, 16'hFFFF);
                         write_reg(REG_CORE_MASK, 8'h00); end
                1: begin write_reg(REG_CYCLES_PER_US, 1); write_reg(REG_QUANTUM_US, 1);
                         write_reg(REG_CORE_MASK, 8'hFF); end
                2: write_reg(REG_CORE_MASK, $urandom_range(0, 255));
                3: begin write_reg(REG_CYCLES_PER_US, 100); write_reg(REG_QUANTUM_US, 50);
                         write_reg(REG_CORE_MASK, 8'hA5); end
                default: begin write_reg(REG_CYCLES_PER_US, 1000); write_reg(REG_QUANTUM_US, 10);
                         write_reg(REG_CORE_MASK, 8'hFF); calm = 1; end
            endcase
            now = rand64();
            repeat (15)
            begin
                now = now + $urandom_range(0, 30000);
                if ($urandom_range(0, 5) == 0)
                    send($urandom_range(0, 7), 22'($urandom()), $urandom_range(0, 7), rand64(),
                         rand64(), 22'($urandom()), 22'($urandom()), 22'($urandom()),
                         $urandom_range(0, 1));
                else
                    sched_round(now);
            end
            drain();
        end

        $display("sent %0d requests, checked %0d results over %0d passes",
                 sent, results_seen, passes_seen);
        if (fail_count == 0)
            $display("multicore_round_robin_task_scheduler regression: pass");
        else
            $display("multicore_round_robin_task_scheduler regression: fail");
        $finish;
    end
endmodule
